[design/svsfr_pkg.sv]
// shared types, constants and helper functions for the servo status frame receiver
package svsfr_pkg;

  // frame geometry
  localparam int FRAME_LEN = 12;
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  // ascii codes used by the decoder
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_SEVEN = 8'd55;
  localparam logic [7:0] CH_ALARM_FLOOR = 8'h4C;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_SIX = 8'h36;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_BIT_OFF = 2'd2;

  // reset values of the registers
  localparam logic [7:0] FRAME_HEAD_RST = 8'd37;
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd2000;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_T     = 3'd1,
    KIND_F     = 3'd2,
    KIND_C     = 3'd3,
    KIND_D     = 3'd4,
    KIND_OTHER = 3'd5
  } frame_kind_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // held status values, updated by decoded frames
  typedef struct packed {
    logic [5:0]  switch_bits;
    logic [15:0] alarm_code;
    logic [19:0] position;
    logic [13:0] speed;
    logic [3:0]  status_bits;
    logic [7:0]  speed_ratio;
    logic [6:0]  loop_gain;
    logic [6:0]  loop_diff;
    logic [6:0]  loop_integral;
  } held_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       work_started;
  } in_item_t;

  typedef struct packed {
    logic        link_up;
    logic [2:0]  frame_kind;
    logic [5:0]  switch_bits;
    logic [15:0] alarm_code;
    logic [19:0] position;
    logic [13:0] speed;
    logic [3:0]  status_bits;
    logic [7:0]  speed_ratio;
    logic [6:0]  loop_gain;
    logic [6:0]  loop_diff;
    logic [6:0]  loop_integral;
  } out_item_t;

  // ascii digit clamped to 0..9
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = c - CH_ZERO;
      if (c < CH_ZERO) begin
        digit_of = 4'd0;
      end else if (c > CH_ZERO + 8'd9) begin
        digit_of = 4'd9;
      end else begin
        digit_of = d[3:0];
      end
    end
  endfunction

  // two ascii digits to 0..99
  function automatic logic [6:0] digits2(input logic [7:0] hi, input logic [7:0] lo);
    logic [6:0] h;
    logic [6:0] l;
    begin
      h = 7'(digit_of(hi));
      l = 7'(digit_of(lo));
      digits2 = (h << 3) + (h << 1) + l;
    end
  endfunction

endpackage

[design/svsfr_in_if.sv]
// input channel: received bytes and polls
interface svsfr_in_if;
  logic valid;
  logic ready;
  svsfr_pkg::in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/svsfr_out_if.sv]
// output channel: one status result per input transaction
interface svsfr_out_if;
  logic valid;
  logic ready;
  svsfr_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/servo_status_frame_receiver.sv]
// Servo status frame receiver: takes one byte or poll per cycle while no skid entry waits;
// each transaction yields one result, registered and shown the cycle after acceptance when
// the result register is free. A two-entry buffer (result register plus skid register) lets
// the input keep accepting while one result waits, so one transaction per clock holds while
// results are taken; check and decode are one combinational pass from held state to result.
module servo_status_frame_receiver (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [svsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svsfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  svsfr_in_if.sink                           item,
  svsfr_out_if.source                        result
);

  // configuration registers
  logic [7:0]  frame_head;
  logic [15:0] link_timeout;
  logic        cut_bit_off;

  // receiver state
  svsfr_pkg::frame_t                frame_buf;
  logic [svsfr_pkg::CNT_W-1:0]      byte_count;
  logic                             in_frame;
  logic [7:0]                       running_xor;
  logic                             frame_pending;
  logic [15:0]                      link_timer;
  logic                             link_alive;
  svsfr_pkg::held_t                 held;

  logic [svsfr_pkg::CNT_W-1:0]      byte_count_next;
  logic                             in_frame_next;
  logic [7:0]                       running_xor_next;
  logic                             frame_pending_next;
  logic [15:0]                      link_timer_next;
  logic                             link_alive_next;
  svsfr_pkg::held_t                 held_next;
  svsfr_pkg::frame_kind_t           kind_next;
  logic                             buf_we;
  logic [svsfr_pkg::CNT_W-1:0]      buf_addr;

  svsfr_pkg::held_t                 dec_held;
  svsfr_pkg::frame_kind_t           dec_kind;

  // output buffer
  logic                             out_valid;
  svsfr_pkg::out_item_t             out_data;
  logic                             skid_valid;
  svsfr_pkg::out_item_t             skid_data;
  svsfr_pkg::out_item_t             new_result;
  logic                             accept;

  assign item.ready = !skid_valid;
  assign accept = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_head <= svsfr_pkg::FRAME_HEAD_RST;
      link_timeout <= svsfr_pkg::LINK_TIMEOUT_RST;
      cut_bit_off <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        svsfr_pkg::REG_FRAME_HEAD: frame_head <= cfg_data[7:0];
        svsfr_pkg::REG_LINK_TIMEOUT: link_timeout <= cfg_data[15:0];
        svsfr_pkg::REG_CUT_BIT_OFF: cut_bit_off <= cfg_data[0];
        default: ;
      endcase
    end
  end

  svsfr_decode u_decode (
    .frame        (frame_buf),
    .held         (held),
    .work_started (item.data.work_started),
    .cut_bit_off  (cut_bit_off),
    .held_next    (dec_held),
    .kind         (dec_kind)
  );

  // byte framing, poll handling and link timer
  always_comb begin
    byte_count_next = byte_count;
    in_frame_next = in_frame;
    running_xor_next = running_xor;
    frame_pending_next = frame_pending;
    link_timer_next = link_timer;
    link_alive_next = link_alive;
    held_next = held;
    kind_next = svsfr_pkg::KIND_NONE;
    buf_we = 1'b0;
    buf_addr = byte_count;
    if (!item.data.mode) begin
      if (!frame_pending) begin
        if (!in_frame) begin
          if (item.data.rx_byte == frame_head) begin
            buf_we = 1'b1;
            buf_addr = '0;
            byte_count_next = svsfr_pkg::CNT_W'(1);
            running_xor_next = item.data.rx_byte;
            in_frame_next = 1'b1;
          end
        end else begin
          buf_we = 1'b1;
          if (byte_count == svsfr_pkg::LAST_IDX) begin
            frame_pending_next = (running_xor == item.data.rx_byte);
            in_frame_next = 1'b0;
            byte_count_next = '0;
          end else begin
            running_xor_next = running_xor ^ item.data.rx_byte;
            byte_count_next = byte_count + svsfr_pkg::CNT_W'(1);
          end
        end
      end
    end else if (frame_pending) begin
      frame_pending_next = 1'b0;
      link_alive_next = 1'b1;
      link_timer_next = '0;
      held_next = dec_held;
      kind_next = dec_kind;
    end else begin
      if (link_timer != 16'hFFFF) begin
        link_timer_next = link_timer + 16'd1;
      end
      if (link_timer_next > link_timeout) begin
        link_alive_next = 1'b0;
      end
    end
  end

  // result of this transaction: held values after the item
  always_comb begin
    new_result.link_up = link_alive_next;
    new_result.frame_kind = kind_next;
    new_result.switch_bits = held_next.switch_bits;
    new_result.alarm_code = held_next.alarm_code;
    new_result.position = held_next.position;
    new_result.speed = held_next.speed;
    new_result.status_bits = held_next.status_bits;
    new_result.speed_ratio = held_next.speed_ratio;
    new_result.loop_gain = held_next.loop_gain;
    new_result.loop_diff = held_next.loop_diff;
    new_result.loop_integral = held_next.loop_integral;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      in_frame <= 1'b0;
      running_xor <= '0;
      frame_pending <= 1'b0;
      link_timer <= '0;
      link_alive <= 1'b0;
      held <= '0;
    end else if (accept) begin
      byte_count <= byte_count_next;
      in_frame <= in_frame_next;
      running_xor <= running_xor_next;
      frame_pending <= frame_pending_next;
      link_timer <= link_timer_next;
      link_alive <= link_alive_next;
      held <= held_next;
    end
  end

  // frame buffer, no reset
  always_ff @(posedge clk) begin
    if (accept && buf_we) begin
      frame_buf[buf_addr] <= item.data.rx_byte;
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= new_result;
      end
    end else if (accept) begin
      skid_data <= new_result;
    end
  end

`ifndef SYNTH
  // skid entry is only used behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the result register is empty");

  // a held frame and an open frame never coexist
  a_pending_not_framing: assert property (@(posedge clk) disable iff (rst)
    !(frame_pending && in_frame))
    else $error("frame pending while still collecting a frame");

  // byte counter stays inside the frame
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= svsfr_pkg::LAST_IDX)
    else $error("byte counter beyond frame length");

  // a poll that takes a pending frame marks the link alive
  a_poll_decodes: assert property (@(posedge clk) disable iff (rst)
    accept && item.data.mode && frame_pending |=> !frame_pending && link_alive
      && link_timer == 16'd0)
    else $error("poll did not consume the pending frame");

  // every accepted transaction produces a result
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction left no result");
`endif

endmodule

[design/svsfr_decode.sv]
// combinational decoder of one complete frame into updated held values
module svsfr_decode (
  input  svsfr_pkg::frame_t      frame,
  input  svsfr_pkg::held_t       held,
  input  logic                   work_started,
  input  logic                   cut_bit_off,
  output svsfr_pkg::held_t       held_next,
  output svsfr_pkg::frame_kind_t kind
);

  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic [7:0] b4;
  logic [19:0] pos_val;
  logic [13:0] speed_val;
  logic [3:0] pd [0:5];
  logic [3:0] sd [0:3];

  assign b1 = frame[1];
  assign b2 = frame[2];
  assign b3 = frame[3];
  assign b4 = frame[4];

  // six digit position from bytes 5..10
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pd[k] = svsfr_pkg::digit_of(frame[5 + k]);
    end
    pos_val = 20'(pd[0]) * 20'd100000 + 20'(pd[1]) * 20'd10000 + 20'(pd[2]) * 20'd1000
            + 20'(pd[3]) * 20'd100 + 20'(pd[4]) * 20'd10 + 20'(pd[5]);
  end

  // four digit speed from bytes 7..10
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sd[k] = svsfr_pkg::digit_of(frame[7 + k]);
    end
    speed_val = 14'(sd[0]) * 14'd1000 + 14'(sd[1]) * 14'd100 + 14'(sd[2]) * 14'd10
              + 14'(sd[3]);
  end

  // per-type update of the held values
  always_comb begin
    held_next = held;
    kind = svsfr_pkg::KIND_OTHER;
    case (b1)
      svsfr_pkg::CH_T: begin
        kind = svsfr_pkg::KIND_T;
        if (b3 >= svsfr_pkg::CH_ALARM_FLOOR) begin
          held_next.alarm_code = {b3, b4};
        end else begin
          held_next.alarm_code = '0;
          if (work_started) begin
            held_next.position = pos_val;
          end
          // limit switch character
          if (b3 >= svsfr_pkg::CH_ZERO && b3 <= svsfr_pkg::CH_SEVEN) begin
            held_next.switch_bits[2:0] = b3[2:0];
          end
          // clamp, cutter, carrier character
          if (b4 >= svsfr_pkg::CH_ZERO && b4 <= svsfr_pkg::CH_SEVEN) begin
            held_next.switch_bits[3] = b4[0];
            if (!cut_bit_off) begin
              held_next.switch_bits[4] = b4[1];
            end
            held_next.switch_bits[5] = b4[2];
          end
        end
      end
      svsfr_pkg::CH_F: begin
        kind = svsfr_pkg::KIND_F;
        held_next.speed_ratio = b2;
        case (b3)
          svsfr_pkg::CH_N: held_next.status_bits[1:0] = 2'b00;
          svsfr_pkg::CH_D: held_next.status_bits[1:0] = 2'b01;
          svsfr_pkg::CH_R: held_next.status_bits[1:0] = 2'b10;
          default: held_next.status_bits[1:0] = held.status_bits[1:0];
        endcase
        held_next.speed = speed_val;
      end
      svsfr_pkg::CH_C, svsfr_pkg::CH_D: begin
        kind = (b1 == svsfr_pkg::CH_C) ? svsfr_pkg::KIND_C : svsfr_pkg::KIND_D;
        // ir sensor
        if (b2 == svsfr_pkg::CH_TWO || b2 == svsfr_pkg::CH_THREE) begin
          held_next.status_bits[2] = 1'b0;
        end else if (b2 == svsfr_pkg::CH_SIX || b2 == svsfr_pkg::CH_SEVEN) begin
          held_next.status_bits[2] = 1'b1;
        end
        // handwheel, c frames only
        if (b1 == svsfr_pkg::CH_C) begin
          if (b3 == svsfr_pkg::CH_X) begin
            held_next.status_bits[3] = 1'b1;
          end else if (b3 == svsfr_pkg::CH_S) begin
            held_next.status_bits[3] = 1'b0;
          end
        end
        held_next.loop_gain = svsfr_pkg::digits2(frame[4], frame[5]);
        held_next.loop_diff = svsfr_pkg::digits2(frame[6], frame[7]);
        held_next.loop_integral = svsfr_pkg::digits2(frame[8], frame[9]);
      end
      default: begin
        kind = svsfr_pkg::KIND_OTHER;
      end
    endcase
  end

endmodule
